### design/ctrv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTRV motion prediction package
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ctrv_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int THR_WIDTH      = 16;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd66;

  // CORDIC works in Q30 with 30 rotations.
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam longint TWO_PI_Q32 = 64'sd26986075409;

  // Arctangent table for each rotation, Q30.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = CW'(34'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/ctrv_motion_predict_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTRV motion prediction top level
// Propagates one sigma point through the constant turn rate and velocity
// model with saturating fixed-point arithmetic.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle when the output is not
// stalled. The item passes 105 register stages: two input stages, 33
// sine/cosine stages (three for range reduction and 30 CORDIC rotations),
// two arc stages, 67 divider stages (input register and 66 quotient bits)
// and the output register. A stall on a valid output item freezes the entire
// pipeline; the output register holds its item.
module ctrv_motion_predict_top import ctrv_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [THR_WIDTH-1:0]          cfg_yaw_rate_threshold,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [DATA_WIDTH-1:0]  in_position_x,
  input  wire signed [DATA_WIDTH-1:0]  in_position_y,
  input  wire signed [DATA_WIDTH-1:0]  in_speed,
  input  wire signed [DATA_WIDTH-1:0]  in_heading,
  input  wire signed [DATA_WIDTH-1:0]  in_yaw_rate,
  input  wire signed [DATA_WIDTH-1:0]  in_accel_noise,
  input  wire signed [DATA_WIDTH-1:0]  in_yaw_accel_noise,
  input  wire [FRAC_BITS+3:0]          in_time_step,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [DATA_WIDTH-1:0] out_next_x,
  output logic signed [DATA_WIDTH-1:0] out_next_y,
  output logic signed [DATA_WIDTH-1:0] out_next_speed,
  output logic signed [DATA_WIDTH-1:0] out_next_heading,
  output logic signed [DATA_WIDTH-1:0] out_next_yaw_rate
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * W + 2;
  localparam int TRIG_LAT = 3 + CORDIC_STEPS;
  localparam int DIV_LAT  = NW + 1;
  // Stage plan: s1 products, s2 sat adds, trig(TRIG_LAT), s3 diff/products,
  // s4 arc products, divider (DIV_LAT), output.
  localparam int LAT_A = 3 + TRIG_LAT;
  localparam int LAT_B = 2 + DIV_LAT;
  localparam int TOT   = LAT_A + LAT_B;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Saturating add and Q multiply helpers.
  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = W'(0) + {a[W-1], a} + {b[W-1], b};
    if (s > $signed({MAXV[W-1], MAXV})) return MAXV;
    if (s < $signed({MINV[W-1], MINV})) return MINV;
    return W'(s);
  endfunction

  function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic [W-1:0]   ma, mb;
    logic [2*W-1:0] p, s, lim;
    logic           ng;
    ma  = a[W-1] ? W'(-a) : W'(a);
    mb  = b[W-1] ? W'(-b) : W'(b);
    ng  = a[W-1] ^ b[W-1];
    p   = (2*W)'(ma) * (2*W)'(mb);
    s   = p >> FRAC_BITS;
    lim = ((2*W)'(1) << (W-1)) - (ng ? (2*W)'(0) : (2*W)'(1));
    if (s > lim) s = lim;
    return W'(ng ? -s : s);
  endfunction

  // Pipeline advance and handshakes.
  logic en;
  assign en        = !out_stall || !out_valid;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  logic [THR_WIDTH-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else if (cfg_valid && cfg_ready) thr_r <= cfg_yaw_rate_threshold;
  end

  logic [TOT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[TOT-2:0], in_valid};
  end
  assign out_valid = vld_r[TOT-1];

  // Stage 1: first products.
  logic signed [W-1:0] tsx;
  assign tsx = W'($signed({1'b0, in_time_step}));
  logic signed [W-1:0] x1_r, y1_r, v1_r, p1_r, w1_r, na1_r, nj1_r, wt1_r, tt1_r, t1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_position_x; y1_r <= in_position_y; v1_r <= in_speed;
      p1_r <= in_heading; w1_r <= in_yaw_rate; na1_r <= in_accel_noise;
      nj1_r <= in_yaw_accel_noise; t1_r <= tsx;
      wt1_r <= mulq(in_yaw_rate, tsx);
      tt1_r <= mulq(tsx, tsx);
    end
  end

  // Stage 2: angle, half t squared, path select and noise products.
  logic signed [W-1:0] ang2_r, h2_r, x2_r, y2_r, v2_r, p2_r, w2_r, vt2_r, nat2_r;
  logic signed [W-1:0] na2_r, nj2_r, njt2_r;
  logic                arc2_r;
  logic [W-1:0]        wmag;
  assign wmag = w1_r[W-1] ? W'(-w1_r) : W'(w1_r);
  always_ff @(posedge clk) begin
    if (en) begin
      ang2_r <= sadd(p1_r, wt1_r);
      h2_r   <= tt1_r >>> 1;
      x2_r <= x1_r; y2_r <= y1_r; v2_r <= v1_r; p2_r <= p1_r; w2_r <= w1_r;
      na2_r <= na1_r; nj2_r <= nj1_r;
      arc2_r <= wmag > W'(thr_r);
      vt2_r  <= mulq(v1_r, t1_r);
      nat2_r <= mulq(na1_r, t1_r);
      njt2_r <= mulq(nj1_r, t1_r);
    end
  end

  // Trigonometry of heading and of the advanced angle.
  logic signed [W-1:0] s0, c0, s1, c1;
  ctrv_sincos #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(W)) u_trig0 (
    .clk(clk), .en(en), .ang(p2_r), .sin_q(s0), .cos_q(c0));
  ctrv_sincos #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(W)) u_trig1 (
    .clk(clk), .en(en), .ang(ang2_r), .sin_q(s1), .cos_q(c1));

  // Delay line for values that travel alongside the trigonometry.
  typedef struct packed {
    logic signed [W-1:0] x, y, v, w, ang, h, vt, nat, na, nj, njt;
    logic                arc;
  } side_t;
  side_t side_d [TRIG_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= '{x: x2_r, y: y2_r, v: v2_r, w: w2_r, ang: ang2_r, h: h2_r,
                     vt: vt2_r, nat: nat2_r, na: na2_r, nj: nj2_r, njt: njt2_r,
                     arc: arc2_r};
      for (int k = 1; k < TRIG_LAT; k++) side_d[k] <= side_d[k-1];
    end
  end
  side_t sa;
  assign sa = side_d[TRIG_LAT-1];

  // Stage 3: arc numerators, straight-line and noise products.
  logic signed [W:0]   ds_r, dc_r;
  logic signed [W-1:0] acc_r, sl_x_r, sl_y_r, c0_r, s0_r, nh_r;
  side_t               s3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ds_r   <= (W+1)'(s1) - (W+1)'(s0);
      dc_r   <= (W+1)'(c0) - (W+1)'(c1);
      acc_r  <= mulq(sa.na, sa.h);
      nh_r   <= mulq(sa.nj, sa.h);
      sl_x_r <= mulq(sa.vt, c0);
      sl_y_r <= mulq(sa.vt, s0);
      c0_r <= c0; s0_r <= s0; s3_r <= sa;
    end
  end

  // Stage 4: v times difference, registered ahead of the dividers.
  logic [NW-1:0] px_r, py_r;
  logic          nx_r, ny_r;
  logic [W-1:0]  wd_r;
  logic [W-1:0]  vm;
  logic [W:0]    dsm, dcm;
  logic signed [W-1:0] ax_r, ay_r;
  side_t         s4_r;
  logic signed [W-1:0] sx4_r, sy4_r;
  always_comb begin
    vm  = s3_r.v[W-1] ? W'(-s3_r.v) : W'(s3_r.v);
    dsm = ds_r[W] ? (W+1)'(-ds_r) : (W+1)'(ds_r);
    dcm = dc_r[W] ? (W+1)'(-dc_r) : (W+1)'(dc_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= NW'(vm) * NW'(dsm);
      py_r <= NW'(vm) * NW'(dcm);
      nx_r <= s3_r.v[W-1] ^ ds_r[W] ^ s3_r.w[W-1];
      ny_r <= s3_r.v[W-1] ^ dc_r[W] ^ s3_r.w[W-1];
      wd_r <= s3_r.w[W-1] ? W'(-s3_r.w) : W'(s3_r.w);
      ax_r <= mulq(acc_r, c0_r);
      ay_r <= mulq(acc_r, s0_r);
      sx4_r <= sl_x_r; sy4_r <= sl_y_r;
      s4_r <= '{x: s3_r.x, y: s3_r.y, v: s3_r.v, w: s3_r.w,
                ang: sadd(s3_r.ang, nh_r), h: s3_r.h, vt: s3_r.vt,
                nat: s3_r.nat, na: s3_r.na, nj: s3_r.nj, njt: s3_r.njt,
                arc: s3_r.arc};
    end
  end

  logic signed [W-1:0] qx, qy;
  ctrv_divider #(.NW(NW), .DW(W), .DATA_WIDTH(W)) u_divx (
    .clk(clk), .en(en), .num(px_r), .den(wd_r), .neg(nx_r), .quo(qx));
  ctrv_divider #(.NW(NW), .DW(W), .DATA_WIDTH(W)) u_divy (
    .clk(clk), .en(en), .num(py_r), .den(wd_r), .neg(ny_r), .quo(qy));

  typedef struct packed {
    logic signed [W-1:0] x, y, v, w, ang, nat, njt, sx, sy, ax, ay;
    logic                arc;
  } tail_t;
  tail_t tail_d [DIV_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      tail_d[0] <= '{x: s4_r.x, y: s4_r.y, v: s4_r.v, w: s4_r.w, ang: s4_r.ang,
                     nat: s4_r.nat, njt: s4_r.njt, sx: sx4_r, sy: sy4_r,
                     ax: ax_r, ay: ay_r, arc: s4_r.arc};
      for (int k = 1; k < DIV_LAT; k++) tail_d[k] <= tail_d[k-1];
    end
  end
  tail_t tb;
  assign tb = tail_d[DIV_LAT-1];

  // Final adds into the output register.
  logic signed [W-1:0] xp, yp;
  always_comb begin
    xp = sadd(tb.x, tb.arc ? qx : tb.sx);
    yp = sadd(tb.y, tb.arc ? qy : tb.sy);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_next_x        <= sadd(xp, tb.ax);
      out_next_y        <= sadd(yp, tb.ay);
      out_next_speed    <= sadd(tb.v, tb.nat);
      out_next_heading  <= tb.ang;
      out_next_yaw_rate <= sadd(tb.w, tb.njt);
    end
  end

`ifndef SYNTH
  // A stalled output item must stay valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("output item dropped");
  // Input is stalled only while the output is stalled.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid) else $error("spurious input stall");
  // An accepted item enters the valid pipeline.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0]) else $error("item lost on entry");
`endif

endmodule
`default_nettype wire

### design/ctrv_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTRV sine/cosine pipeline
// Range reduction followed by a fully pipelined rotation-mode CORDIC,
// one rotation per stage. Stall freezes every stage.
// ----------------------------------------------------------------------------
module ctrv_sincos import ctrv_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire signed [DATA_WIDTH-1:0]  ang,
  output logic signed [DATA_WIDTH-1:0] sin_q,
  output logic signed [DATA_WIDTH-1:0] cos_q
);

  localparam longint PERIOD =
    (TWO_PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam int PW = $clog2(PERIOD) + 1;
  localparam int QW = DATA_WIDTH + 1;
  localparam int NS = CORDIC_STEPS;

  // Stage A: quotient of the angle magnitude by the period, estimated with a
  // constant reciprocal about DATA_WIDTH bits wide. The estimate is exact or
  // low by one; stage B corrects it.
  localparam int RS = FRAC_BITS + 3;
  localparam logic [RS+DATA_WIDTH:0] RECIP =
    ((RS+DATA_WIDTH+1)'(1) << (RS + DATA_WIDTH - 1)) / (RS+DATA_WIDTH+1)'(PERIOD);

  logic signed [DATA_WIDTH-1:0] a0_r;
  logic                         a0_neg_r;
  logic [DATA_WIDTH:0]          qt_r;
  logic [DATA_WIDTH:0]          mag;
  logic [2*DATA_WIDTH+RS:0]     qprod;

  always_comb begin
    mag   = ang[DATA_WIDTH-1] ? (DATA_WIDTH+1)'(-$signed({ang[DATA_WIDTH-1], ang}))
                              : (DATA_WIDTH+1)'({1'b0, ang});
    qprod = (2*DATA_WIDTH+RS+1)'(mag) * (2*DATA_WIDTH+RS+1)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r     <= ang;
      a0_neg_r <= ang[DATA_WIDTH-1];
      qt_r     <= (DATA_WIDTH+1)'(qprod >> (RS + DATA_WIDTH - 1));
    end
  end

  // Stage B: remainder of the magnitude, corrected, then mapped to [0, 2pi).
  logic signed [QW+PW:0] rem_m;
  logic signed [QW+PW:0] r_pos;
  logic [PW-1:0]         r_r;

  always_comb begin
    rem_m = (QW+PW+1)'($signed({1'b0,
              (a0_neg_r ? (DATA_WIDTH+1)'(-$signed({a0_r[DATA_WIDTH-1], a0_r}))
                        : (DATA_WIDTH+1)'({1'b0, a0_r}))}))
            - (QW+PW+1)'($signed({1'b0, qt_r})) * (QW+PW+1)'(PERIOD);
    if (rem_m >= (QW+PW+1)'(PERIOD)) rem_m = rem_m - (QW+PW+1)'(PERIOD);
    if (rem_m >= (QW+PW+1)'(PERIOD)) rem_m = rem_m - (QW+PW+1)'(PERIOD);
    r_pos = rem_m;
    if (a0_neg_r && rem_m != '0) r_pos = (QW+PW+1)'(PERIOD) - rem_m;
  end

  always_ff @(posedge clk) begin
    if (en) r_r <= PW'(r_pos);
  end

  // Stage C: move to Q30 and fold into [-pi/2, pi/2].
  logic signed [CW-1:0] z0;
  logic                 fl0;

  always_comb begin
    z0  = CW'($signed({1'b0, r_r})) <<< (30 - FRAC_BITS);
    fl0 = 1'b0;
    if (z0 > PI_Q30) z0 = z0 - TWO_PI_Q30;
    if (z0 > HALF_PI_Q30) begin
      z0 = z0 - PI_Q30; fl0 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z0 = z0 + PI_Q30; fl0 = 1'b1;
    end
  end

  // CORDIC stages, one rotation each.
  logic signed [CW-1:0] x_r [NS+1];
  logic signed [CW-1:0] y_r [NS+1];
  logic signed [CW-1:0] z_r [NS+1];
  logic                 f_r [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= z0;
      f_r[0] <= fl0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  // Floor back to the output format and undo the fold.
  logic signed [CW-1:0] xs, ys;
  always_comb begin
    xs    = x_r[NS] >>> (30 - FRAC_BITS);
    ys    = y_r[NS] >>> (30 - FRAC_BITS);
    sin_q = DATA_WIDTH'(f_r[NS] ? -ys : ys);
    cos_q = DATA_WIDTH'(f_r[NS] ? -xs : xs);
  end

endmodule
`default_nettype wire

### design/ctrv_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CTRV pipelined restoring divider
// Divides an unsigned dividend by an unsigned divisor, one quotient bit per
// stage, and gives a saturated signed result.
// ----------------------------------------------------------------------------
module ctrv_divider import ctrv_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire [NW-1:0]                 num,
  input  wire [DW-1:0]                 den,
  input  wire                          neg,
  output logic signed [DATA_WIDTH-1:0] quo
);

  logic [NW-1:0] n_r [NW+1];
  logic [DW:0]   r_r [NW+1];
  logic [NW-1:0] q_r [NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic          s_r [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= num; r_r[0] <= '0; q_r[0] <= '0; d_r[0] <= den; s_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [DW+1:0] sh;
    assign sh = {r_r[i], n_r[i][NW-1-i]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i];
        d_r[i+1] <= d_r[i];
        s_r[i+1] <= s_r[i];
        if (sh >= (DW+2)'(d_r[i])) begin
          r_r[i+1] <= (DW+1)'(sh - (DW+2)'(d_r[i]));
          q_r[i+1] <= q_r[i] | (NW'(1) << (NW-1-i));
        end else begin
          r_r[i+1] <= (DW+1)'(sh);
          q_r[i+1] <= q_r[i];
        end
      end
    end
  end

  // Saturate to the signed range; a zero divisor gives the limit.
  localparam logic [NW-1:0] LIM_P = NW'((65'd1 << (DATA_WIDTH-1)) - 65'd1);
  logic [NW-1:0] lim, mg;
  always_comb begin
    lim = s_r[NW] ? LIM_P + NW'(1) : LIM_P;
    mg  = (d_r[NW] == '0 || q_r[NW] > lim) ? lim : q_r[NW];
    quo = DATA_WIDTH'(s_r[NW] ? -mg : mg);
  end

endmodule
`default_nettype wire

### dv/ctrv_motion_predict_top_tb.sv
// ----------------------------------------------------------------------------
// CTRV motion prediction testbench
// Drives sigma points through the block under random idling on both sides.
// A bit-accurate predictor with its own CORDIC works out each expected state
// that the directed table does not give directly. Several threshold settings
// are used, and every result is checked in order.
module ctrv_motion_predict_top_tb;
  import ctrv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DW          = DATA_WIDTH_DEF;
  localparam int     FB          = FRAC_BITS_DEF;
  localparam int     TW          = FB + 4;
  localparam longint S_MAX       = 64'sd2147483647;
  localparam longint S_MIN       = -64'sd2147483648;
  localparam longint ANGLE_PI    = 64'sd3373259426;
  localparam longint ANGLE_2PI   = 64'sd6746518852;
  localparam longint ANGLE_HPI   = 64'sd1686629713;
  localparam longint ROT_GAIN    = 64'sd652032874;
  localparam longint TURN_Q32    = 64'sd26986075409;
  localparam int     PIPE_DRAIN  = 150;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     N_RANDOM    = 1020;

  typedef struct {
    logic signed [DW-1:0] px, py, spd, hdg, yaw, an, jn;
    logic [TW-1:0]        dt;
  } sigma_t;

  typedef struct {
    logic signed [DW-1:0] nx, ny, nspd, nhdg, nyaw;
  } state_t;

  typedef struct {
    sigma_t pt;
    bit     known;
    state_t res;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_WIDTH-1:0] cfg_yaw_rate_threshold = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_position_x = '0, in_position_y = '0, in_speed = '0;
  logic signed [DW-1:0] in_heading = '0, in_yaw_rate = '0;
  logic signed [DW-1:0] in_accel_noise = '0, in_yaw_accel_noise = '0;
  logic [TW-1:0] in_time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_next_x, out_next_y, out_next_speed;
  logic signed [DW-1:0] out_next_heading, out_next_yaw_rate;

  ctrv_motion_predict_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_yaw_rate_threshold(cfg_yaw_rate_threshold),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_position_x(in_position_x), .in_position_y(in_position_y),
    .in_speed(in_speed), .in_heading(in_heading), .in_yaw_rate(in_yaw_rate),
    .in_accel_noise(in_accel_noise), .in_yaw_accel_noise(in_yaw_accel_noise),
    .in_time_step(in_time_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_next_x(out_next_x), .out_next_y(out_next_y),
    .out_next_speed(out_next_speed), .out_next_heading(out_next_heading),
    .out_next_yaw_rate(out_next_yaw_rate)
  );

  longint   turn_threshold = 66;
  state_t   pending_states[$];
  int       errors = 0;
  int       cycles = 0;
  int       sent = 0;
  int       checked = 0;
  int       arc_count = 0;
  bit       calm = 1'b0;
  longint   rot_angle[30];

  initial begin
    forever #10 clk = ~clk;
  end

  // Saturate a magnitude with a sign to the data range.
  function automatic longint clamp_mag(longint unsigned mag, bit neg);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > S_MAX) return S_MAX;
    if (s < S_MIN) return S_MIN;
    return s;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Fixed-point product, truncated toward zero.
  function automatic longint qmul(longint a, longint b);
    longint unsigned p;
    p = abs_of(a) * abs_of(b);
    return clamp_mag(p >> FB, (a < 0) != (b < 0));
  endfunction

  // Exact a*b divided by c, truncated toward zero.
  function automatic longint qmuldiv(longint a, longint b, longint c);
    longint unsigned p;
    bit neg;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    p = abs_of(a) * abs_of(b);
    if (c == 0) return clamp_mag(64'hFFFF_FFFF_FFFF, neg);
    return clamp_mag(p / abs_of(c), neg);
  endfunction

  // Range reduction and a 30-step CORDIC rotation in Q30.
  function automatic void trig(input longint ang, output longint sn, output longint cs);
    longint period, r, x, y, z, dx, dy;
    bit flip;
    period = (TURN_Q32 + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
    r = ang % period;
    if (r < 0) r += period;
    z = r <<< (30 - FB);
    flip = 1'b0;
    if (z > ANGLE_PI) z -= ANGLE_2PI;
    if (z > ANGLE_HPI) begin
      z -= ANGLE_PI;
      flip = 1'b1;
    end else if (z < -ANGLE_HPI) begin
      z += ANGLE_PI;
      flip = 1'b1;
    end
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= rot_angle[i];
      end else begin
        x += dx; y -= dy; z += rot_angle[i];
      end
    end
    x = x >>> (30 - FB);
    y = y >>> (30 - FB);
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // Propagate one sigma point through the motion model.
  function automatic state_t propagate(sigma_t p);
    state_t o;
    longint x, y, v, psi, w, na, nj, t, ang, h, s0, c0, s1, c1, xp, yp, vt, acc;
    x = p.px; y = p.py; v = p.spd; psi = p.hdg; w = p.yaw;
    na = p.an; nj = p.jn; t = longint'({1'b0, p.dt});
    ang = clamp_add(psi, qmul(w, t));
    h = qmul(t, t) >>> 1;
    trig(psi, s0, c0);
    if (abs_of(w) > turn_threshold) begin
      trig(ang, s1, c1);
      xp = clamp_add(x, qmuldiv(v, s1 - s0, w));
      yp = clamp_add(y, qmuldiv(v, c0 - c1, w));
    end else begin
      vt = qmul(v, t);
      xp = clamp_add(x, qmul(vt, c0));
      yp = clamp_add(y, qmul(vt, s0));
    end
    acc = qmul(na, h);
    o.nx = DW'(clamp_add(xp, qmul(acc, c0)));
    o.ny = DW'(clamp_add(yp, qmul(acc, s0)));
    o.nspd = DW'(clamp_add(v, qmul(na, t)));
    o.nhdg = DW'(clamp_add(ang, qmul(nj, h)));
    o.nyaw = DW'(clamp_add(w, qmul(nj, t)));
    return o;
  endfunction

  task automatic write_threshold(input logic [THR_WIDTH-1:0] thr);
    cfg_valid <= 1'b1;
    cfg_yaw_rate_threshold <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    turn_threshold = thr;
  endtask

  // Present one item after a random gap and hold it until accepted.
  task automatic send_point(input sigma_t p, input bit known, input state_t res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position_x <= p.px; in_position_y <= p.py; in_speed <= p.spd;
    in_heading <= p.hdg; in_yaw_rate <= p.yaw; in_accel_noise <= p.an;
    in_yaw_accel_noise <= p.jn; in_time_step <= p.dt;
    do @(posedge clk); while (in_stall);
    if (abs_of(longint'(p.yaw)) > turn_threshold) arc_count++;
    pending_states.push_back(known ? res : propagate(p));
    sent++;
  endtask

  function automatic logic signed [DW-1:0] rand_word();
    return DW'($urandom());
  endfunction

  // Mostly moderate, well-scaled motion; the rest spans every field fully.
  function automatic sigma_t random_point();
    sigma_t p;
    p.px = rand_word(); p.py = rand_word(); p.spd = rand_word();
    p.hdg = rand_word(); p.yaw = rand_word(); p.an = rand_word();
    p.jn = rand_word(); p.dt = TW'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      p.spd = $signed($urandom_range(0, 40 << FB)) - (10 << FB);
      p.hdg = $signed($urandom_range(0, 14 << FB)) - (7 << FB);
      p.an = $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      p.jn = $signed($urandom_range(0, 4 << FB)) - (2 << FB);
      p.dt = TW'($urandom_range(0, 1 << FB));
      case ($urandom_range(0, 2))
        0: p.yaw = $signed($urandom_range(0, 4 << FB)) - (2 << FB);
        1: p.yaw = DW'($signed(turn_threshold) + $signed($urandom_range(0, 4)) - 2);
        default: p.yaw = DW'(-$signed(turn_threshold) + $signed($urandom_range(0, 4)) - 2);
      endcase
    end
    return p;
  endfunction

  // Output side: stall for a random count per item, sometimes not at all.
  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each delivered item with the oldest expectation.
  always @(posedge clk) begin
    state_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_states.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        e = pending_states.pop_front();
        checked++;
        if (out_next_x !== e.nx) begin
          $error("next_x: expected %0d, got %0d", e.nx, out_next_x); errors++;
        end
        if (out_next_y !== e.ny) begin
          $error("next_y: expected %0d, got %0d", e.ny, out_next_y); errors++;
        end
        if (out_next_speed !== e.nspd) begin
          $error("next_speed: expected %0d, got %0d", e.nspd, out_next_speed); errors++;
        end
        if (out_next_heading !== e.nhdg) begin
          $error("next_heading: expected %0d, got %0d", e.nhdg, out_next_heading); errors++;
        end
        if (out_next_yaw_rate !== e.nyaw) begin
          $error("next_yaw_rate: expected %0d, got %0d", e.nyaw, out_next_yaw_rate);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_states.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (pending_states.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Main sequence: directed table, then random phases per threshold.
  initial begin
    vector_t vec[$];
    vector_t v;
    state_t none;
    logic [THR_WIDTH-1:0] phase_thr[5];
    none = '{default: '0};
    rot_angle = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                  16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                  131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                  128, 64, 32, 16, 8, 4, 2};

    // A zero time step leaves the state unchanged on either path.
    v.pt = '{px: 0, py: 0, spd: 0, hdg: 0, yaw: 0, an: 0, jn: 0, dt: 0};
    v.known = 1; v.res = '{0, 0, 0, 0, 0};
    vec.push_back(v);
    v.pt = '{px: 32'sh7FFFFFFF, py: 32'sh80000000, spd: 32'sh7FFFFFFF,
             hdg: 32'sh80000000, yaw: 32'sh7FFFFFFF, an: 32'sh80000000,
             jn: 32'sh7FFFFFFF, dt: 0};
    v.res = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    vec.push_back(v);
    v.pt = '{px: 5 << FB, py: -3 << FB, spd: 12 << FB, hdg: 1 << FB, yaw: 0,
             an: 1 << FB, jn: 1 << FB, dt: 0};
    v.res = '{5 << FB, -3 << FB, 12 << FB, 1 << FB, 0};
    vec.push_back(v);
    // Heading and yaw rate at the top: the new heading saturates.
    v.pt = '{px: 0, py: 0, spd: 0, hdg: 32'sh7FFFFFFF, yaw: 32'sh7FFFFFFF,
             an: 0, jn: 0, dt: 20'hFFFFF};
    v.res = '{0, 0, 32'sh0, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    vec.push_back(v);
    // Remaining rows are checked against the predictor.
    v.known = 0;
    v.pt = '{0, 0, 10 << FB, 0, 0, 0, 0, 1 << FB}; vec.push_back(v);
    v.pt = '{0, 0, 10 << FB, 3 << FB, 66, 0, 0, 1 << FB}; vec.push_back(v);
    v.pt = '{0, 0, 10 << FB, 3 << FB, 67, 0, 0, 1 << FB}; vec.push_back(v);
    v.pt = '{0, 0, 10 << FB, -2 << FB, -67, 0, 0, 1 << FB}; vec.push_back(v);
    v.pt = '{0, 0, 8 << FB, 1 << FB, 1 << FB, 0, 0, 1 << FB}; vec.push_back(v);
    v.pt = '{0, 0, -8 << FB, -1 << FB, -1 << FB, 2 << FB, -2 << FB, 20'hFFFFF};
    vec.push_back(v);
    v.pt = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 0,
             32'sh7FFFFFFF, 32'sh80000000, 20'hFFFFF}; vec.push_back(v);
    v.pt = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
             32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 20'hFFFFF}; vec.push_back(v);
    v.pt = '{0, 0, 32'sh7FFFFFFF, 1 << FB, 1, 0, 0, 1}; vec.push_back(v);
    v.pt = '{0, 0, 1 << FB, 32'sh00064000, 32'sh00010000, 0, 0, 20'h08000};
    vec.push_back(v);
    v.pt = '{-1, -1, -1, -1, -1, -1, -1, 20'hFFFFF}; vec.push_back(v);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_threshold(THR_RESET);
    foreach (vec[i]) send_point(vec[i].pt, vec[i].known, vec[i].res);
    in_valid <= 1'b0;
    drain();

    phase_thr = '{16'd0, 16'hFFFF, 16'd66, THR_WIDTH'($urandom()), 16'd1};
    foreach (phase_thr[ph]) begin
      write_threshold(phase_thr[ph]);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_point(random_point(), 1'b0, none);
      end
      in_valid <= 1'b0;
      calm = 1'b0;
      drain();
    end

    $display("Sent %0d sigma points (%0d on the arc path), checked %0d results.",
             sent, arc_count, checked);
    $display("Thresholds covered: reset value, zero, full scale and random.");
    if (errors == 0 && pending_states.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
